[sv/ufhg_pkg.sv]
// shared types and constants of the udp/ipv4 fragment header generator
// no dependencies
package ufhg_pkg;

    localparam int UDP_HDR_LEN   = 8;
    localparam int MAX_PAYLOAD   = 65507;
    localparam int PAYLOAD_W     = 17;
    localparam int IN_TDATA_W    = 24;
    localparam int OUT_TDATA_W   = 112;
    localparam int OUT_TUSER_W   = 3;
    localparam int APB_ADDR_W    = 5;
    localparam int APB_DATA_W    = 32;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_TOO_BIG = 2'd1;
    localparam logic [1:0] STATUS_BAD_SEG = 2'd2;

    typedef enum logic [2:0] {
        REG_MAX_UDP_PAYLOAD  = 3'd0,
        REG_MAX_IP_PAYLOAD   = 3'd1,
        REG_IP_HEADER_LEN    = 3'd2,
        REG_L2_HEADER_LEN    = 3'd3,
        REG_TOTAL_HEADER_LEN = 3'd4,
        REG_MAX_INLINE       = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [15:0] max_udp_payload;
        logic [15:0] max_ip_payload;
        logic [5:0]  ip_header_len;
        logic [6:0]  l2_header_len;
        logic [7:0]  total_header_len;
        logic [9:0]  max_inline;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        max_udp_payload:  16'd1480,
        max_ip_payload:   16'd1480,
        ip_header_len:    6'd20,
        l2_header_len:    7'd14,
        total_header_len: 8'd42,
        max_inline:       10'd204
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_CMP,
        ST_DIV,
        ST_FSEL,
        ST_FRAG
    } state_t;

    typedef struct packed {
        logic load_in;
        logic emit_single;
        logic setup;
        logic div_start;
        logic div_step;
        logic use_mask;
        logic use_max;
        logic emit_frag;
    } dp_cmd_t;

    typedef struct packed {
        logic single_res;
        logic fits_prod;
        logic more;
        logic out_free;
    } dp_status_t;

endpackage

[sv/ufhg_regs.sv]
// apb configuration registers of the fragment header generator
// depends on ufhg_pkg
module ufhg_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ufhg_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [ufhg_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [ufhg_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    output ufhg_pkg::cfg_t                      cfg
);
    import ufhg_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_MAX_UDP_PAYLOAD:  cfg_next.max_udp_payload  = pwdata[15:0];
                REG_MAX_IP_PAYLOAD:   cfg_next.max_ip_payload   = pwdata[15:0];
                REG_IP_HEADER_LEN:    cfg_next.ip_header_len    = pwdata[5:0];
                REG_L2_HEADER_LEN:    cfg_next.l2_header_len    = pwdata[6:0];
                REG_TOTAL_HEADER_LEN: cfg_next.total_header_len = pwdata[7:0];
                REG_MAX_INLINE:       cfg_next.max_inline       = pwdata[9:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_MAX_UDP_PAYLOAD:  prdata = APB_DATA_W'(cfg_reg.max_udp_payload);
            REG_MAX_IP_PAYLOAD:   prdata = APB_DATA_W'(cfg_reg.max_ip_payload);
            REG_IP_HEADER_LEN:    prdata = APB_DATA_W'(cfg_reg.ip_header_len);
            REG_L2_HEADER_LEN:    prdata = APB_DATA_W'(cfg_reg.l2_header_len);
            REG_TOTAL_HEADER_LEN: prdata = APB_DATA_W'(cfg_reg.total_header_len);
            REG_MAX_INLINE:       prdata = APB_DATA_W'(cfg_reg.max_inline);
            default:              prdata = '0;
        endcase
    end

endmodule

[sv/ufhg_ctrl.sv]
// controller state machine of the fragment header generator
// depends on ufhg_pkg
module ufhg_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  ufhg_pkg::dp_status_t    status,
    output ufhg_pkg::dp_cmd_t       cmd
);
    import ufhg_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_valid)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (!status.single_res)
                begin
                    state_next = ST_CMP;
                end
                else if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_CMP:
            begin
                state_next = status.fits_prod ? ST_FRAG : ST_DIV;
            end
            ST_DIV:
            begin
                state_next = ST_FSEL;
            end
            ST_FSEL:
            begin
                state_next = ST_FRAG;
            end
            ST_FRAG:
            begin
                if (status.out_free && !status.more)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_ready     = 1'b1;
                cmd.load_in = s_valid;
            end
            ST_EVAL:
            begin
                cmd.emit_single = status.single_res && status.out_free;
                cmd.setup       = !status.single_res;
            end
            ST_CMP:
            begin
                cmd.use_mask  = status.fits_prod;
                cmd.div_start = !status.fits_prod;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            ST_FSEL:
            begin
                cmd.use_max = 1'b1;
            end
            ST_FRAG:
            begin
                cmd.emit_frag = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

[sv/ufhg_dpath.sv]
// datapath of the fragment header generator: request register, fragment
// size divider, offset counters and output register; depends on ufhg_pkg
module ufhg_dpath #(
    parameter int MAX_FRAGMENTS = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ufhg_pkg::cfg_t                      cfg,
    input  ufhg_pkg::dp_cmd_t                   cmd,
    output ufhg_pkg::dp_status_t                status,
    input  logic [ufhg_pkg::IN_TDATA_W-1:0]     in_tdata,
    output logic                                out_tvalid,
    input  logic                                out_tready,
    output logic [ufhg_pkg::OUT_TDATA_W-1:0]    out_tdata,
    output logic [ufhg_pkg::OUT_TUSER_W-1:0]    out_tuser,
    output logic                                out_tlast
);
    import ufhg_pkg::*;

    localparam int          PROD_W    = 16 + $clog2(MAX_FRAGMENTS + 1);
    localparam int          DIVISOR   = 8 * MAX_FRAGMENTS;
    // 17-bit value over DIVISOR by a rounded-up reciprocal, exact for all 17-bit inputs
    localparam int          RCP_SH    = 17 + $clog2(DIVISOR);
    localparam int          QP_W      = RCP_SH + 13;
    localparam longint unsigned RCP   =
        ((64'd1 << RCP_SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);

    // request
    logic [PAYLOAD_W-1:0] payload_reg;
    logic                 single_reg;
    logic                 bad_reg;

    // fragment run
    logic [16:0]          cur_udp_reg;
    logic [16:0]          ip_off_reg;
    logic [16:0]          ip_off_next;
    logic [16:0]          user_off_reg;
    logic [16:0]          user_off_next;
    logic [15:0]          ident_ctr_reg;
    logic [15:0]          ident_ctr_next;
    logic [15:0]          cur_ident_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [15:0]          fsize_reg;

    // divider
    logic [16:0]          num_reg;
    logic [QP_W-1:0]      quot_prod_reg;

    // output register
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [OUT_TDATA_W-1:0]  out_tdata_reg;
    logic [OUT_TUSER_W-1:0]  out_tuser_reg;
    logic                    out_tlast_reg;

    // single result
    logic        big;
    logic [17:0] udp_sum;
    logic        fits;
    logic [17:0] inline_sum;
    logic        inl;
    logic [15:0] seg_single;
    logic [15:0] tot_single;
    logic [1:0]  err_status;
    logic [OUT_TDATA_W-1:0] single_tdata;

    // fragment result
    logic [15:0] fsize_mask;
    logic [16:0] rem_len;
    logic        more;
    logic        first;
    logic [15:0] sz;
    logic [15:0] cp;
    logic [15:0] ulen;
    logic [12:0] off8;
    logic [OUT_TDATA_W-1:0] frag_tdata;

    // divider result
    logic [15:0]    need;

    assign big        = payload_reg > PAYLOAD_W'(MAX_PAYLOAD);
    assign udp_sum    = {1'b0, payload_reg} + 18'(UDP_HDR_LEN);
    assign fits       = udp_sum <= {2'b00, cfg.max_udp_payload};
    assign inline_sum = {1'b0, payload_reg} + 18'(cfg.total_header_len);
    assign inl        = single_reg && (inline_sum < 18'(cfg.max_inline));
    assign seg_single = inl ? payload_reg[15:0]
                            : payload_reg[15:0] + 16'(cfg.l2_header_len)
                              + 16'(cfg.ip_header_len) + 16'(UDP_HDR_LEN);
    assign tot_single = 16'(cfg.ip_header_len) + udp_sum[15:0];
    assign err_status = bad_reg ? STATUS_BAD_SEG : (big ? STATUS_TOO_BIG : STATUS_OK);

    assign single_tdata = (bad_reg || big) ? '0 :
        {seg_single, 16'd0, payload_reg[15:0], 16'd0, 14'd0, tot_single,
         udp_sum[15:0], 1'b1, inl};

    assign fsize_mask = {cfg.max_ip_payload[15:3], 3'b000};
    assign rem_len    = cur_udp_reg - ip_off_reg;
    assign more       = rem_len > {1'b0, fsize_reg};
    assign first      = ip_off_reg == '0;
    assign sz         = more ? fsize_reg : rem_len[15:0];
    assign cp         = first ? sz - 16'(UDP_HDR_LEN) : sz;
    assign ulen       = first ? cur_udp_reg[15:0] : 16'd0;
    assign off8       = first ? 13'd0 : ip_off_reg[15:3];

    assign frag_tdata =
        {sz + 16'(cfg.l2_header_len) + 16'(cfg.ip_header_len),
         user_off_reg[15:0], cp, cur_ident_reg, more, off8,
         16'(cfg.ip_header_len) + sz, ulen, 1'b0, 1'b0};

    assign ip_off_next   = ip_off_reg + {1'b0, sz};
    assign user_off_next = user_off_reg + {1'b0, cp};
    assign ident_ctr_next = ident_ctr_reg + 16'd1;

    // quotient is at most a 13-bit value for any fragment limit
    assign need  = {quot_prod_reg[RCP_SH +: 13], 3'b000};

    assign status.single_res = bad_reg || big || fits;
    assign status.fits_prod  = prod_reg >= PROD_W'(cur_udp_reg);
    assign status.more       = more;
    assign status.out_free   = !out_valid_reg || out_tready;

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            payload_reg <= in_tdata[PAYLOAD_W-1:0];
            single_reg  <= in_tdata[PAYLOAD_W];
            bad_reg     <= in_tdata[PAYLOAD_W+1];
        end
        if (cmd.setup)
        begin
            cur_udp_reg   <= udp_sum[16:0];
            cur_ident_reg <= ident_ctr_reg;
            prod_reg      <= PROD_W'(fsize_mask) * PROD_W'(MAX_FRAGMENTS);
        end
        if (cmd.setup)
        begin
            ip_off_reg   <= '0;
            user_off_reg <= '0;
        end
        else if (cmd.emit_frag)
        begin
            ip_off_reg   <= ip_off_next;
            user_off_reg <= user_off_next;
        end
        if (cmd.div_start)
        begin
            num_reg <= 17'(cur_udp_reg + 17'(DIVISOR - 1));
        end
        if (cmd.div_step)
        begin
            quot_prod_reg <= QP_W'(num_reg) * QP_W'(RCP);
        end
        if (cmd.use_mask)
        begin
            fsize_reg <= fsize_mask;
        end
        else if (cmd.use_max)
        begin
            fsize_reg <= (need > fsize_mask) ? need : fsize_mask;
        end
        if (cmd.emit_single)
        begin
            out_tdata_reg <= single_tdata;
            out_tuser_reg <= {1'b0, err_status};
            out_tlast_reg <= 1'b1;
        end
        else if (cmd.emit_frag)
        begin
            out_tdata_reg <= frag_tdata;
            out_tuser_reg <= {1'b1, STATUS_OK};
            out_tlast_reg <= !more;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit_single || cmd.emit_frag)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            ident_ctr_reg <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cmd.setup)
            begin
                ident_ctr_reg <= ident_ctr_next;
            end
        end
    end

    assign out_tvalid = out_valid_reg;
    assign out_tdata  = out_tdata_reg;
    assign out_tuser  = out_tuser_reg;
    assign out_tlast  = out_tlast_reg;

endmodule

[sv/udp_ipv4_fragment_header_gen_unit.sv]
// top level of the udp/ipv4 fragment header generator
// depends on ufhg_pkg, ufhg_regs, ufhg_ctrl, ufhg_dpath
//
// takes one udp send request per transaction and returns one descriptor for an
// error or unfragmented datagram, or a tlast-terminated run of ip fragment
// descriptors. one request is worked on at a time; a fragmented one is set up in
// the eval and cmp states, then gives one fragment per cycle while the output is
// free. when max_ip_payload is too small to keep the run within MAX_FRAGMENTS, the
// fragment size comes from a reciprocal multiplication in the div and fsel states.
// results sit in an output register, so a new request is taken while the last
// result waits. configuration is written over apb at byte address 4*index; the
// user must write it only while the block is idle, the block does not enforce it.
module udp_ipv4_fragment_header_gen_unit #(
    parameter int MAX_FRAGMENTS = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // payload_len[16:0], single_segment[17], bad_segment[18], zero pad
    input  logic [ufhg_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // use_inline, l4_csum_offload, udp_length, ip_total_len, frag_field,
    // ip_ident, copy_len, data_offset, segment_len
    output logic [ufhg_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // status[1:0], fragmented[2]
    output logic [ufhg_pkg::OUT_TUSER_W-1:0]    m_axis_tuser,
    output logic                                m_axis_tlast,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ufhg_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [ufhg_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [ufhg_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import ufhg_pkg::*;

    cfg_t       cfg;
    dp_cmd_t    cmd;
    dp_status_t status;

    ufhg_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ufhg_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .status  (status),
        .cmd     (cmd)
    );

    ufhg_dpath #(
        .MAX_FRAGMENTS (MAX_FRAGMENTS)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .cmd        (cmd),
        .status     (status),
        .in_tdata   (s_axis_tdata),
        .out_tvalid (m_axis_tvalid),
        .out_tready (m_axis_tready),
        .out_tdata  (m_axis_tdata),
        .out_tuser  (m_axis_tuser),
        .out_tlast  (m_axis_tlast)
    );

endmodule

[tb/tb_top.sv]
// self-checking testbench for udp_ipv4_fragment_header_gen_unit
// depends on ufhg_pkg and the rtl of the unit; predicts every descriptor and checks it
`timescale 1ns / 100ps

module tb_top;

    import ufhg_pkg::*;

    localparam int FRAG_LIMIT     = 64;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 24;
    localparam int MAX_REPORTS    = 100;
    localparam logic [13:0] MF_FLAG = 14'h2000;

    typedef struct packed {
        logic        bad;
        logic        single;
        logic [16:0] payload;
    } req_t;

    typedef struct {
        logic [1:0]  status;
        logic        fragmented;
        logic        use_inline;
        logic        l4_csum;
        logic [15:0] udp_length;
        logic [15:0] ip_total_len;
        logic [13:0] frag_field;
        logic [15:0] ip_ident;
        logic [15:0] copy_len;
        logic [15:0] data_offset;
        logic [15:0] segment_len;
        logic        is_last;
    } desc_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [IN_TDATA_W-1:0]   s_axis_tdata = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;
    logic [OUT_TUSER_W-1:0]  m_axis_tuser;
    logic                    m_axis_tlast;
    logic                    psel = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]   paddr = '0;
    logic [APB_DATA_W-1:0]   pwdata = '0;
    logic [APB_DATA_W-1:0]   prdata;
    logic                    pready;

    cfg_t        cfg = CFG_RESET;
    logic [15:0] frag_ident = 16'd0;
    req_t        request_q[$];
    desc_t       pending_desc[$];

    int tx_hold = 0;
    int rx_hold = 0;
    int tx_gap_pct = 0;
    int rx_stall_pct = 0;
    bit quiet = 1'b0;
    int stall_cycles = 0;

    int mismatches = 0;
    int n_requests = 0;
    int n_descs = 0;
    int n_frag_dgrams = 0;
    int n_errors = 0;
    int n_settings = 1;

    udp_ipv4_fragment_header_gen_unit #(
        .MAX_FRAGMENTS (FRAG_LIMIT)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #6 clk = ~clk;

    function automatic void predict_descriptors(input req_t r);
        desc_t       d;
        int unsigned pay, udp_len, fsize, need, count, sz, ip_off, user_off, cp;
        logic [15:0] ident;
        d = '{default: '0};
        d.is_last = 1'b1;
        pay = r.payload;
        n_requests++;
        if (r.bad) begin
            d.status = STATUS_BAD_SEG;
            n_errors++;
            pending_desc.push_back(d);
            return;
        end
        if (pay > MAX_PAYLOAD) begin
            d.status = STATUS_TOO_BIG;
            n_errors++;
            pending_desc.push_back(d);
            return;
        end
        udp_len = pay + UDP_HDR_LEN;
        if (udp_len <= cfg.max_udp_payload) begin
            d.use_inline   = r.single && (pay + cfg.total_header_len < cfg.max_inline);
            d.l4_csum      = 1'b1;
            d.udp_length   = 16'(udp_len);
            d.ip_total_len = 16'(cfg.ip_header_len + udp_len);
            d.copy_len     = 16'(pay);
            d.segment_len  = d.use_inline ? 16'(pay)
                : 16'(pay + cfg.l2_header_len + cfg.ip_header_len + UDP_HDR_LEN);
            pending_desc.push_back(d);
            return;
        end
        // fragment size: low bits dropped, then raised to keep the run within the limit
        fsize = cfg.max_ip_payload & ~32'd7;
        need = (udp_len + FRAG_LIMIT - 1) / FRAG_LIMIT;
        need = (need + 7) & ~32'd7;
        if (fsize < need)
            fsize = need;
        count = (udp_len + fsize - 1) / fsize;
        ident = frag_ident;
        frag_ident = frag_ident + 16'd1;
        n_frag_dgrams++;
        ip_off = 0;
        user_off = 0;
        for (int unsigned n = 0; n < count && n < FRAG_LIMIT; n++)
        begin
            sz = (udp_len - ip_off < fsize) ? udp_len - ip_off : fsize;
            d = '{default: '0};
            d.fragmented   = 1'b1;
            d.ip_ident     = ident;
            d.ip_total_len = 16'(cfg.ip_header_len + sz);
            d.is_last      = (n + 1 >= count);
            d.frag_field   = d.is_last ? 14'd0 : MF_FLAG;
            if (ip_off == 0)
            begin
                cp = sz - UDP_HDR_LEN;
                d.udp_length = 16'(udp_len);
            end
            else
            begin
                cp = sz;
                d.frag_field = d.frag_field | 14'((ip_off / 8) & 32'h1FFF);
            end
            d.copy_len    = 16'(cp);
            d.data_offset = 16'(user_off);
            d.segment_len = 16'(sz + cfg.l2_header_len + cfg.ip_header_len);
            pending_desc.push_back(d);
            ip_off   = (ip_off + sz) & 32'h1FFFF;
            user_off = (user_off + cp) & 32'h1FFFF;
        end
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch on descriptor %0d: %s", n_descs, what);
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] exp);
        if (got !== exp)
            report_mismatch($sformatf("%s is %h, expected %h", name, got, exp));
    endtask

    // request driver
    always @(posedge clk)
    begin : drive_requests
        req_t r;
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (tx_hold > 0)
            begin
                tx_hold <= tx_hold - 1;
                s_axis_tvalid <= 1'b0;
            end
            else if (request_q.size() == 0)
                s_axis_tvalid <= 1'b0;
            else if (!quiet && $urandom_range(99) < tx_gap_pct)
            begin
                tx_hold <= $urandom_range(8);
                s_axis_tvalid <= 1'b0;
            end
            else
            begin
                r = request_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {5'd0, r};
            end
        end
    end

    // descriptor receiver back-pressure
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (rx_hold > 0)
        begin
            rx_hold <= rx_hold - 1;
            m_axis_tready <= 1'b0;
        end
        else if (!quiet && $urandom_range(99) < rx_stall_pct)
        begin
            rx_hold <= $urandom_range(8);
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    // monitor: predict on request transaction, check on descriptor transaction
    always @(posedge clk)
    begin : monitor
        desc_t got;
        desc_t exp;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                predict_descriptors(req_t'(s_axis_tdata[18:0]));
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.use_inline   = m_axis_tdata[0];
                got.l4_csum      = m_axis_tdata[1];
                got.udp_length   = m_axis_tdata[17:2];
                got.ip_total_len = m_axis_tdata[33:18];
                got.frag_field   = m_axis_tdata[47:34];
                got.ip_ident     = m_axis_tdata[63:48];
                got.copy_len     = m_axis_tdata[79:64];
                got.data_offset  = m_axis_tdata[95:80];
                got.segment_len  = m_axis_tdata[111:96];
                got.status       = m_axis_tuser[1:0];
                got.fragmented   = m_axis_tuser[2];
                got.is_last      = m_axis_tlast;
                if (pending_desc.size() == 0)
                    report_mismatch("descriptor with no request waiting");
                else
                begin
                    exp = pending_desc.pop_front();
                    check_field("status", got.status, exp.status);
                    check_field("fragmented", got.fragmented, exp.fragmented);
                    check_field("use_inline", got.use_inline, exp.use_inline);
                    check_field("l4_csum_offload", got.l4_csum, exp.l4_csum);
                    check_field("udp_length", got.udp_length, exp.udp_length);
                    check_field("ip_total_len", got.ip_total_len, exp.ip_total_len);
                    check_field("frag_field", got.frag_field, exp.frag_field);
                    check_field("ip_ident", got.ip_ident, exp.ip_ident);
                    check_field("copy_len", got.copy_len, exp.copy_len);
                    check_field("data_offset", got.data_offset, exp.data_offset);
                    check_field("segment_len", got.segment_len, exp.segment_len);
                    check_field("tlast", got.is_last, exp.is_last);
                end
                n_descs++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (psel && penable))
            stall_cycles <= 0;
        else if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[udp_ipv4_fragment_header_gen_unit] ERROR");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    task automatic apb_write(input reg_idx_t idx, input int unsigned value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_MAX_UDP_PAYLOAD:  cfg.max_udp_payload  = 16'(value);
            REG_MAX_IP_PAYLOAD:   cfg.max_ip_payload   = 16'(value);
            REG_IP_HEADER_LEN:    cfg.ip_header_len    = 6'(value);
            REG_L2_HEADER_LEN:    cfg.l2_header_len    = 7'(value);
            REG_TOTAL_HEADER_LEN: cfg.total_header_len = 8'(value);
            REG_MAX_INLINE:       cfg.max_inline       = 10'(value);
            default: ;
        endcase
    endtask

    task automatic load_settings(input cfg_t c);
        apb_write(REG_MAX_UDP_PAYLOAD, c.max_udp_payload);
        apb_write(REG_MAX_IP_PAYLOAD, c.max_ip_payload);
        apb_write(REG_IP_HEADER_LEN, c.ip_header_len);
        apb_write(REG_L2_HEADER_LEN, c.l2_header_len);
        apb_write(REG_TOTAL_HEADER_LEN, c.total_header_len);
        apb_write(REG_MAX_INLINE, c.max_inline);
        n_settings++;
        @(negedge clk);
    endtask

    task automatic queue_request(input int unsigned payload, input bit single, input bit bad);
        req_t r;
        r.payload = 17'(payload);
        r.single = single;
        r.bad = bad;
        request_q.push_back(r);
    endtask

    // mostly small datagrams, with boundary hits and a tail of large or oversized ones
    task automatic queue_random(input int count);
        int p;
        int unsigned sel;
        for (int i = 0; i < count; i++)
        begin
            sel = $urandom_range(99);
            if (sel < 35)
                p = $urandom_range(300);
            else if (sel < 60)
                p = $urandom_range(3000);
            else if (sel < 72)
                p = int'(cfg.max_udp_payload) - 8 + int'($urandom_range(4)) - 2;
            else if (sel < 80)
                p = int'(cfg.max_inline) - int'(cfg.total_header_len)
                    + int'($urandom_range(2)) - 1;
            else if (sel < 92)
                p = $urandom_range(65507, 3000);
            else if (sel < 96)
                p = 65507 - int'($urandom_range(8));
            else
                p = $urandom_range(131071, 65500);
            if (p < 0)
                p = 0;
            if (p > 131071)
                p = 131071;
            queue_request(p, $urandom_range(1), $urandom_range(11) == 0);
        end
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (request_q.size() != 0 || s_axis_tvalid || pending_desc.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        cfg_t c;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: error priority, limits, inline and fragment boundaries
        tx_gap_pct = 20;
        rx_stall_pct = 20;
        queue_request(0, 1, 0);
        queue_request(0, 0, 0);
        queue_request(131071, 1, 1);
        queue_request(131071, 0, 0);
        queue_request(65508, 1, 0);
        queue_request(65507, 0, 0);
        queue_request(1472, 1, 0);
        queue_request(1473, 1, 0);
        queue_request(161, 1, 0);
        queue_request(162, 1, 0);
        queue_request(2952, 0, 0);
        queue_request(1480, 1, 0);
        queue_request(100, 0, 1);
        queue_random(80);
        wait_idle();

        // tightest udp limit, odd fragment size, widest inline window
        c = '{max_udp_payload: 16'd8, max_ip_payload: 16'd1031, ip_header_len: 6'd20,
              l2_header_len: 7'd0, total_header_len: 8'd255, max_inline: 10'd1023};
        load_settings(c);
        tx_gap_pct = 0;
        rx_stall_pct = 35;
        queue_request(0, 1, 0);
        queue_request(1, 1, 0);
        queue_request(65507, 0, 0);
        queue_request(1016, 1, 0);
        queue_request(1017, 0, 0);
        queue_random(80);
        wait_idle();

        // widest limits and headers: length fields wrap, inline never taken
        c = '{max_udp_payload: 16'd65535, max_ip_payload: 16'd65528, ip_header_len: 6'd60,
              l2_header_len: 7'd64, total_header_len: 8'd0, max_inline: 10'd0};
        load_settings(c);
        tx_gap_pct = 35;
        rx_stall_pct = 0;
        queue_request(65507, 1, 0);
        queue_request(0, 1, 0);
        queue_request(65508, 0, 0);
        queue_request(1000, 1, 0);
        queue_random(80);
        wait_idle();

        for (int k = 0; k < 2; k++)
        begin
            c.max_udp_payload = $urandom_range(1) ? 16'($urandom_range(9000, 8))
                                                  : 16'($urandom_range(65535, 8));
            c.max_ip_payload = 16'($urandom_range(65528, 1024));
            if ($urandom_range(1))
                c.max_ip_payload = 16'($urandom_range(2000, 1024));
            c.ip_header_len = 6'($urandom_range(60, 20));
            c.l2_header_len = 7'($urandom_range(64));
            c.total_header_len = 8'($urandom_range(255));
            c.max_inline = 10'($urandom_range(1023));
            load_settings(c);
            tx_gap_pct = 25;
            rx_stall_pct = 25;
            queue_random(40);
            wait_idle();
        end

        // back to reset values, both sides at full rate
        load_settings(CFG_RESET);
        quiet = 1'b1;
        queue_random(80);
        wait_idle();

        $display("covered %0d requests under %0d register settings: %0d fragmented, %0d rejected",
                 n_requests, n_settings, n_frag_dgrams, n_errors);
        $display("checked %0d descriptors, %0d mismatches", n_descs, mismatches);
        if (mismatches == 0)
            $display("[udp_ipv4_fragment_header_gen_unit] OK");
        else
            $display("[udp_ipv4_fragment_header_gen_unit] ERROR");
        $finish;
    end

endmodule

[files.f]
sv/ufhg_pkg.sv
sv/ufhg_regs.sv
sv/ufhg_ctrl.sv
sv/ufhg_dpath.sv
sv/udp_ipv4_fragment_header_gen_unit.sv
tb/tb_top.sv
